// File: sv/gtm_pkg.sv
// Package for the Goertzel tone magnitude unit.
// Holds widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package gtm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 40;
    localparam int COEF_W    = 16;
    localparam int BLEN_W    = 13;
    localparam int MAG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;
    localparam int MAX_BLOCK = 4096;

    localparam int MUL_A_W   = ACC_W;
    localparam int MUL_B_W   = COEF_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 65;
    localparam int ROOT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TWO_COS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COS       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIN       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = CFG_IDX_W'(3);

    localparam logic signed [COEF_W-1:0] RST_TWO_COS   = -16'sd23170;
    localparam logic signed [COEF_W-1:0] RST_COS       = -16'sd23170;
    localparam logic signed [COEF_W-1:0] RST_SIN       = 16'sd23170;
    localparam logic        [BLEN_W-1:0] RST_BLOCK_LEN = BLEN_W'(120);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_UPD,
        ST_MCOS,
        ST_RE,
        ST_IM,
        ST_SQM,
        ST_SQA,
        ST_RINIT,
        ST_ROOT,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

// File: sv/goertzel_tone_magnitude_unit.sv
// Goertzel single-bin tone magnitude unit, top level.
// Depends on gtm_pkg for widths, register indexes and the state type.
// Per sample: accept, multiply, update; the shared 40x17 multiplier sets the pace.
// Block end: rotate, square/accumulate, check, 32 square-root steps, 32 divide steps,
// output load (an overflow skips to it); then the output register holds it.
// Reset (synchronous, i_rst_n low) restores register defaults and clears the recursion state.
module goertzel_tone_magnitude_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gtm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [gtm_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [gtm_pkg::MAG_W-1:0]       m_axis_tdata,   // [15:0] magnitude
    output logic                            m_axis_tuser    // [0] saturated
);
    import gtm_pkg::*;

    t_state r_state, n_state;

    logic signed [COEF_W-1:0] r_two_cos, r_cos, r_sin;
    logic        [BLEN_W-1:0] r_blen;
    logic        [BLEN_W-1:0] w_n;

    logic signed [ACC_W-1:0]  r_d1, r_d2;
    logic        [BLEN_W-1:0] r_cnt;
    logic        [BLEN_W-1:0] w_cnt_inc;
    logic signed [ACC_W-1:0]  w_q0;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod, r_prod;

    logic signed [ACC_W+1:0]  r_re;
    logic signed [ACC_W+1:0]  w_im;
    logic        [ACC_W+1:0]  w_abs_re, w_abs_im;
    logic                     w_big;
    logic        [ROOT_W-1:0] r_a, r_b;
    logic        [SUM_W-1:0]  r_sum, w_addend;

    logic        [4:0]        r_iter;
    logic        [63:0]       r_rad;
    logic        [ROOT_W:0]   r_rem;
    logic        [ROOT_W-1:0] r_root;
    logic        [ROOT_W+2:0] w_rem_sh, w_trial, w_rem_sub;
    logic                     w_root_ge;

    logic        [ROOT_W-1:0] r_dvd;
    logic        [BLEN_W-1:0] r_drem;
    logic        [BLEN_W:0]   w_dsh;
    logic                     w_div_ge;

    logic                     r_pend_sat;
    logic                     r_out_valid;
    logic        [MAG_W-1:0]  r_out_mag;
    logic                     r_out_sat;
    logic                     w_out_free;
    logic                     w_blk_end;

    // effective block length
    always_comb begin
        if (r_blen == '0) begin
            w_n = BLEN_W'(1);
        end else if (r_blen > BLEN_W'(MAX_BLOCK)) begin
            w_n = BLEN_W'(MAX_BLOCK);
        end else begin
            w_n = r_blen;
        end
    end

    assign w_cnt_inc  = r_cnt + BLEN_W'(1);
    assign w_blk_end  = (w_cnt_inc >= w_n);
    assign w_q0       = r_prod[ACC_W+13:14] - r_d2
                        + {{(ACC_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
    assign w_prod     = w_mul_a * w_mul_b;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_im     = r_prod[PROD_W-1:15];
    assign w_abs_re = r_re[ACC_W+1] ? (ACC_W+2)'(-r_re) : r_re;
    assign w_abs_im = w_im[ACC_W+1] ? (ACC_W+2)'(-w_im) : w_im;
    assign w_big    = (w_abs_re[ACC_W+1:ROOT_W] != '0) || (w_abs_im[ACC_W+1:ROOT_W] != '0);

    assign w_addend = r_iter[0] ? {1'b0, r_prod[47:0], 16'b0} : {17'b0, r_prod[47:0]};

    assign w_rem_sh  = {r_rem, r_rad[63:62]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_root_ge = (w_rem_sh >= w_trial);
    assign w_rem_sub = w_rem_sh - w_trial;

    assign w_dsh    = {r_drem, r_dvd[ROOT_W-1]};
    assign w_div_ge = (w_dsh >= {1'b0, w_n});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_MAC;
            ST_MAC:   n_state = ST_UPD;
            ST_UPD:   n_state = w_blk_end ? ST_MCOS : ST_IDLE;
            ST_MCOS:  n_state = ST_RE;
            ST_RE:    n_state = ST_IM;
            ST_IM:    n_state = w_big ? ST_EMIT : ST_SQM;
            ST_SQM:   n_state = ST_SQA;
            ST_SQA:   n_state = (r_iter[1:0] == 2'd3) ? ST_RINIT : ST_SQM;
            ST_RINIT: n_state = r_sum[SUM_W-1] ? ST_EMIT : ST_ROOT;
            ST_ROOT:  if (r_iter == 5'd0) n_state = ST_DIV;
            ST_DIV:   if (r_iter == 5'd0) n_state = ST_EMIT;
            ST_EMIT:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // multiplier operand select and handshake outputs
    always_comb begin
        w_mul_a = r_d1;
        w_mul_b = {r_two_cos[COEF_W-1], r_two_cos};
        unique case (r_state)
            ST_MCOS: begin
                w_mul_a = r_d2;
                w_mul_b = {r_cos[COEF_W-1], r_cos};
            end
            ST_RE: begin
                w_mul_a = r_d2;
                w_mul_b = {r_sin[COEF_W-1], r_sin};
            end
            ST_SQM: begin
                case (r_iter[1:0])
                    2'd0: begin
                        w_mul_a = {8'b0, r_a};
                        w_mul_b = {1'b0, r_a[15:0]};
                    end
                    2'd1: begin
                        w_mul_a = {8'b0, r_a};
                        w_mul_b = {1'b0, r_a[31:16]};
                    end
                    2'd2: begin
                        w_mul_a = {8'b0, r_b};
                        w_mul_b = {1'b0, r_b[15:0]};
                    end
                    default: begin
                        w_mul_a = {8'b0, r_b};
                        w_mul_b = {1'b0, r_b[31:16]};
                    end
                endcase
            end
            default: begin
                w_mul_a = r_d1;
                w_mul_b = {r_two_cos[COEF_W-1], r_two_cos};
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mag;
    assign m_axis_tuser  = r_out_sat;

    // control, configuration and recursion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_two_cos   <= RST_TWO_COS;
            r_cos       <= RST_COS;
            r_sin       <= RST_SIN;
            r_blen      <= RST_BLOCK_LEN;
            r_d1        <= '0;
            r_d2        <= '0;
            r_cnt       <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TWO_COS:   r_two_cos <= i_cfg_data;
                    CFG_COS:       r_cos     <= i_cfg_data;
                    CFG_SIN:       r_sin     <= i_cfg_data;
                    CFG_BLOCK_LEN: r_blen    <= i_cfg_data[BLEN_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_UPD: begin
                    r_d2  <= r_d1;
                    r_d1  <= w_q0;
                    r_cnt <= w_blk_end ? '0 : w_cnt_inc;
                end
                ST_IM: begin
                    r_d1   <= '0;
                    r_d2   <= '0;
                    r_iter <= '0;
                end
                ST_SQA:  r_iter <= r_iter + 5'd1;
                ST_RINIT: r_iter <= 5'd31;
                ST_ROOT: r_iter <= r_iter - 5'd1;
                ST_DIV:  r_iter <= r_iter - 5'd1;
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) r_sample <= s_axis_tdata;
        r_prod <= w_prod;
        case (r_state)
            ST_RE: r_re <= {{2{r_d1[ACC_W-1]}}, r_d1} - r_prod[PROD_W-1:15];
            ST_IM: begin
                r_a        <= w_abs_re[ROOT_W-1:0];
                r_b        <= w_abs_im[ROOT_W-1:0];
                r_sum      <= '0;
                r_pend_sat <= w_big;
            end
            ST_SQA: r_sum <= r_sum + w_addend;
            ST_RINIT: begin
                r_pend_sat <= r_sum[SUM_W-1];
                r_rad      <= r_sum[63:0];
                r_rem      <= '0;
                r_root     <= '0;
            end
            ST_ROOT: begin
                r_rad <= {r_rad[61:0], 2'b00};
                if (w_root_ge) begin
                    r_rem  <= w_rem_sub[ROOT_W:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[ROOT_W:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                if (r_iter == 5'd0) begin
                    r_drem <= '0;
                    r_dvd  <= w_root_ge ? {r_root[ROOT_W-2:0], 1'b1}
                                        : {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            ST_DIV: begin
                if (w_div_ge) begin
                    r_drem <= BLEN_W'(w_dsh - {1'b0, w_n});
                    r_dvd  <= {r_dvd[ROOT_W-2:0], 1'b1};
                end else begin
                    r_drem <= w_dsh[BLEN_W-1:0];
                    r_dvd  <= {r_dvd[ROOT_W-2:0], 1'b0};
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    if (r_pend_sat || (r_dvd[ROOT_W-1:MAG_W] != '0)) begin
                        r_out_mag <= '1;
                        r_out_sat <= 1'b1;
                    end else begin
                        r_out_mag <= r_dvd[MAG_W-1:0];
                        r_out_sat <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: verif/tb_goertzel_tone_magnitude_unit.sv
// Testbench for goertzel_tone_magnitude_unit: directed rows, then random blocks under random stalls.
// Predicts block magnitudes by its Goertzel model or a typed row; compares every result transfer.
// Depends on gtm_pkg and the unit's RTL.
module tb_goertzel_tone_magnitude_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import gtm_pkg::*;

    localparam int     SETTLE_CYC  = 100;
    localparam int     RAND_ITEMS  = 720;
    localparam int     HOLD_CYC    = 400;
    localparam int     TAIL_LEN    = 64;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(9);

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             sat;
    } t_mag;

    typedef enum logic { ROW_SAMPLE, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic                  typed;
        t_mag                  res;
    } t_row;

    localparam t_mag NO_MAG = '{16'd0, 1'b0};

    localparam t_row DIR_ROWS [0:31] = '{
        '{ROW_SAMPLE, '0, 16'd1000, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd1, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{16'd32767, 1'b0}},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{16'd32768, 1'b0}},
        '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{16'd1, 1'b0}},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{16'd0, 1'b0}},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd0, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'hFF9C, 1'b1, '{16'd100, 1'b0}},
        '{ROW_CFG, CFG_SPARE, 16'h0007, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h0005, 1'b1, '{16'd5, 1'b0}},
        '{ROW_CFG, CFG_TWO_COS, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_COS, 16'h8000, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_SIN, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd4, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{16'hFFFF, 1'b1}},
        '{ROW_CFG, CFG_TWO_COS, 16'h8000, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_SIN, 16'h8000, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd120, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h1234, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd2, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h0001, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'hFFFF, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h4000, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'hC000, 1'b0, NO_MAG},
        '{ROW_CFG, CFG_BLOCK_LEN, 16'd3, 1'b0, NO_MAG},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b0, NO_MAG}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [MAG_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;

    goertzel_tone_magnitude_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [COEF_W-1:0] cur_two_cos = RST_TWO_COS;
    logic signed [COEF_W-1:0] cur_cos     = RST_COS;
    logic signed [COEF_W-1:0] cur_sin     = RST_SIN;
    logic        [BLEN_W-1:0] cur_blen    = RST_BLOCK_LEN;
    logic signed [ACC_W-1:0]  tone_q1     = '0;
    logic signed [ACC_W-1:0]  tone_q2     = '0;
    logic        [BLEN_W-1:0] tone_count  = '0;

    t_mag   expected_mags [$];
    t_mag   want;
    int     errors     = 0;
    int     mags_seen  = 0;
    int     sat_seen   = 0;
    int     samples    = 0;
    int     cfg_writes = 0;
    bit     no_gaps    = 1'b0;
    bit     unsettled  = 1'b0;
    longint cycles     = 0;

    function automatic logic [ROOT_W-1:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[ROOT_W-1:0];
    endfunction

    function automatic longint eff_len(input logic [BLEN_W-1:0] b);
        if (b == 0)
            return 1;
        if (b > MAX_BLOCK)
            return MAX_BLOCK;
        return longint'(b);
    endfunction

    task automatic goertzel_update(input logic [SAMPLE_W-1:0] smp, output bit done,
                                   output t_mag res);
        longint            prod;
        longint            q0;
        longint            re;
        longint            im;
        longint            mag_q;
        longint            n_eff;
        logic [64:0]       ua;
        logic [64:0]       ub;
        logic [64:0]       sq_sum;
        logic [ROOT_W-1:0] root;
        prod       = longint'(tone_q1) * longint'(cur_two_cos);
        q0         = (prod >>> 14) - longint'(tone_q2) + longint'($signed(smp));
        tone_q2    = tone_q1;
        tone_q1    = q0[ACC_W-1:0];
        tone_count = tone_count + 1'b1;
        n_eff      = eff_len(cur_blen);
        done       = (longint'(tone_count) >= n_eff);
        res        = '0;
        if (done) begin
            re = longint'(tone_q1) - ((longint'(tone_q2) * longint'(cur_cos)) >>> 15);
            im = (longint'(tone_q2) * longint'(cur_sin)) >>> 15;
            if (re < 0)
                re = -re;
            if (im < 0)
                im = -im;
            if (re >= 64'sh1_0000_0000 || im >= 64'sh1_0000_0000) begin
                res.sat = 1'b1;
            end else begin
                ua     = 65'(re);
                ub     = 65'(im);
                sq_sum = ua * ua + ub * ub;
                if (sq_sum[64]) begin
                    res.sat = 1'b1;
                end else begin
                    root  = int_sqrt(sq_sum[63:0]);
                    mag_q = longint'(root) / n_eff;
                    if (mag_q > 65535)
                        res.sat = 1'b1;
                    else
                        res.mag = mag_q[MAG_W-1:0];
                end
            end
            if (res.sat)
                res.mag = '1;
            tone_q1    = '0;
            tone_q2    = '0;
            tone_count = '0;
        end
    endtask

    function automatic int pick_gap(input bit rx);
        int r;
        r = $urandom_range(0, 99);
        if (!rx && r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 16'h7FFF;
        if (r < 4)
            return 16'h8000;
        if (r < 5)
            return 16'h0000;
        return CFG_W'($urandom);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h7FFF;
        if (r < 16)
            return 16'h8000;
        if (r < 20)
            return 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                               input t_mag typed_res);
        bit   done;
        t_mag res;
        int   gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        goertzel_update(smp, done, res);
        if (done)
            expected_mags.push_back(typed ? typed_res : res);
        samples++;
        unsettled = 1'b1;
        gap = no_gaps ? 0 : pick_gap(1'b0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off register writes until the unit has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        if (unsettled) begin
            while (expected_mags.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYC) @(posedge i_clk);
            unsettled = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TWO_COS:   cur_two_cos = data;
            CFG_COS:       cur_cos     = data;
            CFG_SIN:       cur_sin     = data;
            CFG_BLOCK_LEN: cur_blen    = data[BLEN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_mags.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual mag %0d sat %0b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_mags.pop_front();
                if (m_axis_tdata !== want.mag) begin
                    errors++;
                    $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                             $time, want.mag, m_axis_tdata);
                end
                if (m_axis_tuser !== want.sat) begin
                    errors++;
                    $display("%0t: saturated mismatch, expected %0b, actual %0b",
                             $time, want.sat, m_axis_tuser);
                end
                mags_seen++;
                if (want.sat)
                    sat_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_mags.size());
            $display("tb_goertzel_tone_magnitude_unit failed");
            $finish;
        end
    end

    initial begin
        bit calm;
        bit held;
        int hold;
        int gap;
        calm = 1'b0;
        held = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && mags_seen >= 25) begin
                m_axis_tready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYC) begin
                    @(posedge i_clk);
                    hold++;
                end
                held = 1'b1;
            end else begin
                if ($urandom_range(0, 199) == 0)
                    calm = !calm;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    gap = pick_gap(1'b1);
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int                kind;
        int                eff;
        int                nsmp;
        int                rand_start;
        int                dir_samples;
        int                tail;
        logic [BLEN_W-1:0] blen;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            else
                push_sample(DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end
        dir_samples = samples;

        rand_start = samples;
        while (samples - rand_start < RAND_ITEMS) begin
            kind    = $urandom_range(0, 11);
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(CFG_TWO_COS, pick_coef());
            if ($urandom_range(0, 1))
                write_reg(CFG_COS, pick_coef());
            if ($urandom_range(0, 1))
                write_reg(CFG_SIN, pick_coef());
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_W'($urandom));
            if (kind == 0)
                blen = BLEN_W'($urandom_range(MAX_BLOCK, 8191));
            else if (kind == 1)
                blen = '0;
            else if (kind < 4)
                blen = BLEN_W'($urandom_range(9, 64));
            else
                blen = BLEN_W'($urandom_range(1, 8));
            write_reg(CFG_BLOCK_LEN, {(CFG_W-BLEN_W)'($urandom), blen});
            eff = int'(eff_len(blen));
            if (kind == 0)
                nsmp = $urandom_range(2, 12);
            else
                nsmp = eff * $urandom_range(1, 4)
                     + (($urandom_range(0, 2) == 0) ? $urandom_range(0, eff - 1) : 0);
            repeat (nsmp) push_sample(pick_sample(), 1'b0, NO_MAG);
        end

        // one longer block, driven hard enough to clip
        no_gaps = 1'b0;
        write_reg(CFG_TWO_COS, 16'h7FFF);
        write_reg(CFG_COS, 16'h8000);
        write_reg(CFG_SIN, 16'h7FFF);
        write_reg(CFG_BLOCK_LEN, CFG_W'(TAIL_LEN));
        tail = (int'(tone_count) >= TAIL_LEN) ? 1 : TAIL_LEN - int'(tone_count);
        repeat (tail) push_sample(16'h7FFF, 1'b0, NO_MAG);
        settle();

        $display("run covered %0d samples (%0d directed) and %0d register writes",
                 samples, dir_samples, cfg_writes);
        $display("%0d magnitudes compared, %0d clipped, %0d mismatches",
                 mags_seen, sat_seen, errors);
        if (errors == 0 && expected_mags.size() == 0) begin
            $display("tb_goertzel_tone_magnitude_unit passed");
        end else begin
            $display("tb_goertzel_tone_magnitude_unit failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/gtm_pkg.sv
sv/goertzel_tone_magnitude_unit.sv
verif/tb_goertzel_tone_magnitude_unit.sv
